### hw/rtl/dtcf_pkg.sv
package dtcf_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 7;
    localparam int CNT_MAX     = (1 << CNT_W) - 1;

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_QUERY   = 2'd1;
    localparam logic [1:0] CMD_SEND    = 2'd2;

    localparam logic REG_RING_ENTRIES  = 1'b0;
    localparam logic REG_DEST_CAPACITY = 1'b1;

    localparam logic [6:0]  RING_ENTRIES_RESET  = 7'd64;
    localparam logic [31:0] DEST_CAPACITY_RESET = 32'd16384;

    typedef struct packed {
        logic load;
        logic restart;
        logic send;
        logic fifo_step;
        logic diff;
        logic widen;
        logic emit;
        logic room;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       free_zero;
        logic       fifo_ok;
        logic       space_ok;
    } dp_status_t;

endpackage

### hw/rtl/dma_tx_credit_flow_control.sv
// Transmit credit tracker for one DMA channel.
// Request channel: drive command, size, bucket_address and consumed_sample
// with start high; the request is taken at a clock edge where busy is low.
// Result channel: done pulses for one cycle with has_room, descriptor_valid,
// descriptor and fault; the results hold until the next done pulse. The
// receiver cannot stall, so a result is never held back.
// Restart, send, unknown commands, and a query that finds no free fifo
// entry and cannot retire the head entry, end in the execute state; other
// queries go on to the subtract and space-check states, and if the space
// check fails on the cached consumed count, the sample is widened and both
// run again. No new request is taken while busy; one can be taken in the
// cycle done is high. The marker RAM read at the ring head feeds the fifo
// check; the two 64-bit subtract and compare steps make the space check.
// Configuration: cfg_write with cfg_index 0 (ring_entries) or 1
// (dest_capacity) and cfg_data, taken at once; write only while idle.
// Reset: ring_entries 64, dest_capacity 16384, counts zero, all 64 fifo
// entries free, every marker reads as zero; no clearing pass is needed.
module dma_tx_credit_flow_control (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [15:0] size,
    input  logic [39:0] bucket_address,
    input  logic [31:0] consumed_sample,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic        has_room,
    output logic        descriptor_valid,
    output logic [63:0] descriptor,
    output logic        fault
);

    dtcf_pkg::ctrl_cmd_t  cmd;
    dtcf_pkg::dp_status_t status;

    dtcf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    dtcf_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .command          (command),
        .size             (size),
        .bucket_address   (bucket_address),
        .consumed_sample  (consumed_sample),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .has_room         (has_room),
        .descriptor_valid (descriptor_valid),
        .descriptor       (descriptor),
        .fault            (fault)
    );

endmodule

### hw/rtl/dtcf_ram.sv
module dtcf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dtcf_ctrl.sv
module dtcf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  dtcf_pkg::dp_status_t   status,
    output dtcf_pkg::ctrl_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_DIFF   = 3'd2;
    localparam logic [2:0] ST_SPACE  = 3'd3;
    localparam logic [2:0] ST_DIFF2  = 3'd4;
    localparam logic [2:0] ST_SPACE2 = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.command)
                    dtcf_pkg::CMD_RESTART:
                    begin
                        cmd.restart = 1'b1;
                        cmd.emit    = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    dtcf_pkg::CMD_SEND:
                    begin
                        cmd.send   = 1'b1;
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    dtcf_pkg::CMD_QUERY:
                    begin
                        if (!status.free_zero)
                        begin
                            state_next = ST_DIFF;
                        end
                        else
                        begin
                            cmd.fifo_step = 1'b1;
                            if (status.fifo_ok)
                            begin
                                state_next = ST_DIFF;
                            end
                            else
                            begin
                                cmd.emit   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_SPACE;
            end
            ST_SPACE:
            begin
                if (status.space_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.room   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.widen  = 1'b1;
                    state_next = ST_DIFF2;
                end
            end
            ST_DIFF2:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_SPACE2;
            end
            ST_SPACE2:
            begin
                cmd.emit   = 1'b1;
                cmd.room   = status.space_ok;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/dtcf_datapath.sv
module dtcf_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtcf_pkg::ctrl_cmd_t  cmd,
    output dtcf_pkg::dp_status_t status,
    input  logic [1:0]           command,
    input  logic [15:0]          size,
    input  logic [39:0]          bucket_address,
    input  logic [31:0]          consumed_sample,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output logic                 has_room,
    output logic                 descriptor_valid,
    output logic [63:0]          descriptor,
    output logic                 fault
);

    localparam int IW = dtcf_pkg::IDX_W;
    localparam int CW = dtcf_pkg::CNT_W;

    logic [1:0]  command_reg;
    logic [15:0] size_reg;
    logic [39:0] addr_reg;
    logic [31:0] sample_reg;

    logic [6:0]  ring_reg;
    logic [31:0] cap_reg;

    logic [63:0] sent_reg;
    logic [63:0] consumed_reg;
    logic [63:0] diff_reg;
    logic [CW-1:0] free_reg;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] tail_reg;
    logic [dtcf_pkg::MAX_ENTRIES-1:0] valid_reg;
    logic        head_valid_reg;

    logic        done_reg;
    logic        has_room_reg;
    logic        desc_valid_reg;
    logic [63:0] desc_reg;
    logic        fault_reg;

    logic [CW-1:0] ring_size;
    logic [16:0]   round_sum;
    logic [63:0]   rounded;
    logic [31:0]   widen_hi;
    logic [63:0]   widened;
    logic [63:0]   marker_raw;
    logic [63:0]   marker;
    logic          le_cached;
    logic          le_widened;
    logic [63:0]   space_left;
    logic [63:0]   sent_new;
    logic [IW-1:0] head_next_idx;
    logic [IW-1:0] tail_next_idx;
    logic          free_zero;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                               input logic [CW-1:0] rs);
        logic [IW:0] n;
        n = {1'b0, idx} + {{IW{1'b0}}, 1'b1};
        if (n >= rs)
        begin
            return '0;
        end
        return n[IW-1:0];
    endfunction

    always_comb
    begin
        if (ring_reg == 7'd0)
        begin
            ring_size = CW'(1);
        end
        else if (ring_reg > 7'(dtcf_pkg::MAX_ENTRIES))
        begin
            ring_size = CW'(dtcf_pkg::MAX_ENTRIES);
        end
        else
        begin
            ring_size = ring_reg;
        end
    end

    assign round_sum = {1'b0, size_reg} + 17'd31;
    assign rounded   = {47'd0, round_sum[16:5], 5'd0};

    assign widen_hi = (sample_reg > sent_reg[31:0]) ? (sent_reg[63:32] - 32'd1)
                                                    : sent_reg[63:32];
    assign widened  = {widen_hi, sample_reg};

    assign marker     = head_valid_reg ? marker_raw : 64'd0;
    assign le_cached  = (marker <= consumed_reg);
    assign le_widened = (marker <= widened);

    assign space_left = {32'd0, cap_reg} - diff_reg;
    assign sent_new   = sent_reg + rounded;

    assign head_next_idx = next_idx(head_reg, ring_size);
    assign tail_next_idx = next_idx(tail_reg, ring_size);
    assign free_zero     = (free_reg == '0);

    assign status.command   = command_reg;
    assign status.free_zero = free_zero;
    assign status.fifo_ok   = !free_zero || le_cached || le_widened;
    assign status.space_ok  = !space_left[63] && (rounded <= space_left);

    dtcf_ram #(
        .WIDTH (64),
        .DEPTH (dtcf_pkg::MAX_ENTRIES)
    ) u_marker_ram (
        .clk   (clk),
        .we    (cmd.send && !free_zero),
        .waddr (tail_reg),
        .wdata (sent_new),
        .raddr (head_reg),
        .rdata (marker_raw)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= command;
            size_reg    <= size;
            addr_reg    <= bucket_address;
            sample_reg  <= consumed_sample;
        end
        if (cmd.diff)
        begin
            diff_reg <= sent_reg - consumed_reg;
        end
        if (cmd.emit)
        begin
            desc_reg <= (cmd.send && !free_zero)
                        ? {1'b1, 7'd0, size_reg, addr_reg} : 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg       <= dtcf_pkg::RING_ENTRIES_RESET;
            cap_reg        <= dtcf_pkg::DEST_CAPACITY_RESET;
            sent_reg       <= '0;
            consumed_reg   <= '0;
            free_reg       <= dtcf_pkg::RING_ENTRIES_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            valid_reg      <= '0;
            head_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            has_room_reg   <= 1'b0;
            desc_valid_reg <= 1'b0;
            fault_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == dtcf_pkg::REG_RING_ENTRIES)
                begin
                    ring_reg <= cfg_data[6:0];
                end
                else
                begin
                    cap_reg <= cfg_data;
                end
            end

            head_valid_reg <= valid_reg[head_reg];

            if (cmd.restart)
            begin
                sent_reg     <= {32'd0, sample_reg};
                consumed_reg <= {32'd0, sample_reg};
                free_reg     <= ring_size;
                head_reg     <= '0;
                tail_reg     <= '0;
                valid_reg    <= '0;
            end

            if (cmd.send && !free_zero)
            begin
                sent_reg            <= sent_new;
                free_reg            <= free_reg - CW'(1);
                valid_reg[tail_reg] <= 1'b1;
                tail_reg            <= tail_next_idx;
            end

            if (cmd.fifo_step)
            begin
                consumed_reg <= le_cached ? consumed_reg : widened;
                if (le_cached || le_widened)
                begin
                    head_reg <= head_next_idx;
                    if (free_reg != CW'(dtcf_pkg::CNT_MAX))
                    begin
                        free_reg <= free_reg + CW'(1);
                    end
                end
            end

            if (cmd.widen)
            begin
                consumed_reg <= widened;
            end

            done_reg <= cmd.emit;
            if (cmd.emit)
            begin
                has_room_reg   <= cmd.room;
                desc_valid_reg <= cmd.send && !free_zero;
                fault_reg      <= cmd.send && free_zero;
            end
        end
    end

    assign done             = done_reg;
    assign has_room         = has_room_reg;
    assign descriptor_valid = desc_valid_reg;
    assign descriptor       = desc_reg;
    assign fault            = fault_reg;

endmodule
